// ===== design/bsws_pkg.sv =====
// ----------------------------------------------------------------------------
// bsws_pkg
// Shared types and constants of the bounded stack with search.
// ----------------------------------------------------------------------------
`default_nettype none

package bsws_pkg;

  localparam int unsigned DefaultDepth = 32;

  localparam int unsigned OpW   = 2;
  localparam int unsigned DataW = 32;
  localparam int unsigned CapW  = 6;
  localparam int unsigned CntW  = 6;

  localparam logic [CapW-1:0] CapReset = 6'd32;

  localparam logic [OpW-1:0] OP_PUSH   = 2'd0;
  localparam logic [OpW-1:0] OP_POP    = 2'd1;
  localparam logic [OpW-1:0] OP_SEARCH = 2'd2;
  localparam logic [OpW-1:0] OP_NONE   = 2'd3;

  typedef struct packed {
    logic        [OpW-1:0]   opcode;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            is_empty;
    logic            found;
    logic [CntW-1:0] position;
    logic            rejected;
  } res_t;

endpackage

`default_nettype wire

// ===== design/bounded_stack_with_search.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_search
// Bounded LIFO stack of signed 32-bit words with a bottom-up linear search.
// ----------------------------------------------------------------------------
// A transaction is taken on a clock edge where start is high and busy is low,
// and yields exactly one result, shown for one cycle with res_valid_o high; the
// receiver cannot hold it off. Push, pop and unused opcodes leave busy low, so
// the next transaction may follow at once. A search walks the entry RAM from
// the bottom, one entry per cycle through its single read port, and keeps busy
// high until it hits or passes the top, that is until the first match or, on a
// miss, until all entries up to the count have been read. A search of an empty
// stack does not scan and leaves busy low. The capacity register may be
// written at any idle time; values above DEPTH act as DEPTH, and entries
// above a lowered capacity are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_with_search #(
  parameter int unsigned DEPTH = bsws_pkg::DefaultDepth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire bsws_pkg::req_t                 req_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [bsws_pkg::CapW-1:0]      cfg_wdata_i,
  output logic                                res_valid_o,
  output bsws_pkg::res_t                      res_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > bsws_pkg::CapW) ? CW : bsws_pkg::CapW;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                            state_q, state_d;
  logic [CW-1:0]                   fill_q, fill_d;
  logic [bsws_pkg::CapW-1:0]       cap_q;
  logic [AW-1:0]                   idx_q, idx_d;
  logic [bsws_pkg::DataW-1:0]      key_q, key_d;
  logic                            res_valid_q, res_valid_d;
  bsws_pkg::res_t                  res_q, res_d;

  logic                            accept;
  logic                            push_ok;
  logic                            ram_we;
  logic                            ram_re;
  logic [AW-1:0]                   ram_raddr;
  logic [bsws_pkg::DataW-1:0]      ram_rdata;
  logic [CW-1:0]                   next_pos;

  assign accept  = start && !busy;
  assign busy    = (state_q == ST_SCAN);
  assign push_ok = (MW'(fill_q) < MW'(cap_q)) && (fill_q != CW'(DEPTH));
  assign next_pos = CW'(idx_q) + CW'(1);

  bsws_ram #(
    .Width(bsws_pkg::DataW),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(fill_q[AW-1:0]),
    .wdata_i(req_i.value),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    key_d       = key_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d.found    = 1'b0;
          res_d.position = '0;
          res_d.rejected = 1'b0;
          unique case (req_i.opcode)
            bsws_pkg::OP_PUSH: begin
              if (push_ok) begin
                ram_we = 1'b1;
                fill_d = fill_q + CW'(1);
              end else begin
                res_d.rejected = 1'b1;
              end
              res_valid_d = 1'b1;
            end
            bsws_pkg::OP_POP: begin
              if (fill_q != '0) begin
                fill_d = fill_q - CW'(1);
              end else begin
                res_d.rejected = 1'b1;
              end
              res_valid_d = 1'b1;
            end
            bsws_pkg::OP_SEARCH: begin
              if (fill_q != '0) begin
                ram_re  = 1'b1;
                idx_d   = '0;
                key_d   = req_i.value;
                state_d = ST_SCAN;
              end else begin
                res_valid_d = 1'b1;
              end
            end
            bsws_pkg::OP_NONE: begin
              res_valid_d = 1'b1;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
          res_d.count    = bsws_pkg::CntW'(fill_d);
          res_d.is_empty = (fill_d == '0);
        end
      end
      ST_SCAN: begin
        if (ram_rdata == key_q) begin
          res_d.found    = 1'b1;
          res_d.position = bsws_pkg::CntW'(next_pos);
          res_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end else if (next_pos == fill_q) begin
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_q + AW'(1);
          idx_d     = idx_q + AW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      cap_q       <= bsws_pkg::CapReset;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    key_q <= key_d;
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== design/bsws_ram.sv =====
// ----------------------------------------------------------------------------
// bsws_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bsws_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== tb/stack_search_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_search_checker
// Watches the request, configuration and result channels of the bounded stack,
// keeps its own copy of the stack contents, fill level and capacity, predicts
// the result of every accepted transaction and compares each strobed result
// field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module stack_search_checker #(
  parameter int unsigned DEPTH = bsws_pkg::DefaultDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  bsws_pkg::req_t                req_i,
  input  logic                          cfg_we_i,
  input  logic [bsws_pkg::CapW-1:0]     cfg_wdata_i,
  input  logic                          res_valid_i,
  input  bsws_pkg::res_t                res_i,
  output int unsigned                   failures_o,
  output int unsigned                   pending_o,
  output int unsigned                   checked_o
);

  logic signed [bsws_pkg::DataW-1:0] stack_words [DEPTH];
  int unsigned                       fill_level;
  logic [bsws_pkg::CapW-1:0]         capacity_reg;
  bsws_pkg::res_t                    awaited_results [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    failures_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic bsws_pkg::res_t apply_operation(input bsws_pkg::req_t r);
    bsws_pkg::res_t o;
    int unsigned    room;
    o    = '0;
    room = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
    case (r.opcode)
      bsws_pkg::OP_PUSH: begin
        if (fill_level < room) begin
          stack_words[fill_level] = r.value;
          fill_level++;
        end else begin
          o.rejected = 1'b1;
        end
      end
      bsws_pkg::OP_POP: begin
        if (fill_level > 0) begin
          fill_level--;
        end else begin
          o.rejected = 1'b1;
        end
      end
      bsws_pkg::OP_SEARCH: begin
        for (int unsigned i = 0; i < fill_level; i++) begin
          if (!o.found && stack_words[i] == r.value) begin
            o.found    = 1'b1;
            o.position = bsws_pkg::CntW'(i + 1);
          end
        end
      end
      default: ;
    endcase
    o.count    = bsws_pkg::CntW'(fill_level);
    o.is_empty = (fill_level == 0);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bsws_pkg::res_t want;
    if (!rst_ni) begin
      fill_level   = 0;
      capacity_reg = bsws_pkg::CapReset;
      awaited_results.delete();
      pending_o    = 0;
      failures_o   = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) begin
        capacity_reg = cfg_wdata_i;
      end
      if (start_i && !busy_i) begin
        awaited_results.push_back(apply_operation(req_i));
      end
      if (res_valid_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result strobed with no transaction outstanding");
        end else begin
          want = awaited_results.pop_front();
          check_field("count", res_i.count, want.count);
          check_field("is_empty", res_i.is_empty, want.is_empty);
          check_field("found", res_i.found, want.found);
          check_field("position", res_i.position, want.position);
          check_field("rejected", res_i.rejected, want.rejected);
          checked_o++;
        end
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the bounded stack with a directed sequence of edge cases followed by
// random push, pop and search traffic over a series of capacity settings,
// with random sender gaps; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned Depth      = bsws_pkg::DefaultDepth;
  localparam int unsigned CycleLimit = 400000;

  logic                      clk_i     = 1'b0;
  logic                      rst_ni    = 1'b0;
  logic                      start     = 1'b0;
  logic                      busy;
  bsws_pkg::req_t            req       = '0;
  logic                      cfg_we    = 1'b0;
  logic [bsws_pkg::CapW-1:0] cfg_wdata = '0;
  logic                      res_valid;
  bsws_pkg::res_t            res;

  int unsigned failures;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycles = 0;
  int unsigned n_push = 0, n_pop = 0, n_search = 0, n_none = 0, n_cfg = 0;

  logic signed [bsws_pkg::DataW-1:0] recent_words [$];

  bounded_stack_with_search #(.DEPTH(Depth)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  stack_search_checker #(.DEPTH(Depth)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .res_valid_i (res_valid),
    .res_i       (res),
    .failures_o  (failures),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout with %0d transactions outstanding", pending);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic [bsws_pkg::OpW-1:0] op,
                           input logic signed [bsws_pkg::DataW-1:0] val);
    bsws_pkg::req_t r;
    r.opcode = op;
    r.value  = val;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy);
    case (op)
      bsws_pkg::OP_PUSH: begin
        n_push++;
        recent_words.push_back(val);
        if (recent_words.size() > 24) begin
          void'(recent_words.pop_front());
        end
      end
      bsws_pkg::OP_POP:    n_pop++;
      bsws_pkg::OP_SEARCH: n_search++;
      default:             n_none++;
    endcase
  endtask

  task automatic hold_off(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain;
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
  endtask

  task automatic set_capacity(input logic [bsws_pkg::CapW-1:0] cap);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  function automatic logic signed [bsws_pkg::DataW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return 32'sd0;
      4, 5:    return bsws_pkg::DataW'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [bsws_pkg::DataW-1:0] pick_key();
    if (recent_words.size() != 0 && $urandom_range(0, 9) < 6) begin
      return recent_words[$urandom_range(0, recent_words.size() - 1)];
    end
    return pick_word();
  endfunction

  task automatic run_phase(input int unsigned n, input int unsigned push_w,
                           input bit with_gaps);
    int unsigned r;
    repeat (n) begin
      if (with_gaps && $urandom_range(0, 3) == 0) begin
        hold_off($urandom_range(1, 5));
      end
      r = $urandom_range(0, 99);
      if (r < push_w) begin
        send_item(bsws_pkg::OP_PUSH, pick_word());
      end else if (r < 95) begin
        if ($urandom_range(0, 9) < 6) begin
          send_item(bsws_pkg::OP_POP, pick_word());
        end else begin
          send_item(bsws_pkg::OP_SEARCH, pick_key());
        end
      end else begin
        send_item(bsws_pkg::OP_NONE, pick_word());
      end
    end
  endtask

  initial begin
    logic [bsws_pkg::CapW-1:0] caps [8];
    int unsigned               sizes [8];
    int unsigned               weights [8];
    caps    = '{6'd63, 6'd0, 6'd1, 6'd32, 6'd5, 6'd33, 6'd0, 6'd32};
    sizes   = '{150, 80, 80, 150, 100, 120, 120, 150};
    weights = '{75, 40, 55, 65, 50, 70, 50, 45};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(bsws_pkg::OP_SEARCH, 32'sd0);
    send_item(bsws_pkg::OP_POP, 32'sd0);
    send_item(bsws_pkg::OP_NONE, -32'sd1);
    send_item(bsws_pkg::OP_PUSH, 32'sh8000_0000);
    send_item(bsws_pkg::OP_PUSH, 32'sh7fff_ffff);
    send_item(bsws_pkg::OP_PUSH, 32'sd0);
    send_item(bsws_pkg::OP_PUSH, -32'sd1);
    send_item(bsws_pkg::OP_PUSH, 32'sd0);
    send_item(bsws_pkg::OP_SEARCH, 32'sd0);
    send_item(bsws_pkg::OP_SEARCH, 32'sh7fff_ffff);
    send_item(bsws_pkg::OP_SEARCH, 32'sh8000_0000);
    send_item(bsws_pkg::OP_SEARCH, -32'sd1);
    send_item(bsws_pkg::OP_SEARCH, 32'sd12345);
    send_item(bsws_pkg::OP_NONE, 32'sh5555_5555);
    send_item(bsws_pkg::OP_POP, 32'sd0);
    send_item(bsws_pkg::OP_SEARCH, -32'sd1);
    send_item(bsws_pkg::OP_POP, 32'sd0);
    send_item(bsws_pkg::OP_SEARCH, -32'sd1);

    set_capacity(6'd2);
    send_item(bsws_pkg::OP_PUSH, 32'sd5);
    send_item(bsws_pkg::OP_SEARCH, 32'sd0);
    send_item(bsws_pkg::OP_POP, 32'sd0);
    send_item(bsws_pkg::OP_PUSH, 32'sd6);
    send_item(bsws_pkg::OP_POP, 32'sd0);
    send_item(bsws_pkg::OP_PUSH, 32'sh5555_5555);

    for (int ph = 0; ph < 8; ph++) begin
      set_capacity(ph == 6 ? bsws_pkg::CapW'($urandom_range(0, 63)) : caps[ph]);
      run_phase(sizes[ph], weights[ph], ph != 7);
    end

    drain();
    repeat (Depth + 8) @(posedge clk_i);

    $display("%0d transactions: %0d push, %0d pop, %0d search, %0d unused opcode",
             n_push + n_pop + n_search + n_none, n_push, n_pop, n_search, n_none);
    $display("%0d capacity writes, %0d results compared, %0d mismatches",
             n_cfg, checked, failures);
    if (failures == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
